FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the TTL-ordered queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, checked at every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Concurrent assertion that is also checked while reset is applied.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/ttlq_pkg.sv
// Package of types and constants for the TTL-ordered priority queue.
`default_nettype none

package ttlq_pkg;

    // Number of entries held by the queue (one cell per entry).
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [OCC_W-1:0] t_occ;
    typedef logic [7:0]       t_ttl;
    typedef logic [15:0]      t_tag;
    typedef logic [7:0]       t_dir;

    // Command codes carried by a transaction.
    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_FLUSH   = 2'd3
    } t_cmd;

    // Operation broadcast to every cell in a cycle.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } t_op;

    // One queue entry.
    typedef struct packed {
        t_ttl ttl;
        t_tag tag;
        t_dir dir;
    } t_entry;

    // Control broadcast from the top level to the cells.
    typedef struct packed {
        t_op    op;
        t_entry new_entry;
        t_cnt   count;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/ttlq_cell.sv
// One storage cell of the TTL-ordered queue chain.
`default_nettype none

module ttlq_cell (
    input  wire logic                i_clk,
    input  wire ttlq_pkg::t_cell_ctrl i_ctrl,
    input  wire ttlq_pkg::t_idx      i_index,
    input  wire ttlq_pkg::t_entry    i_prev_entry,
    input  wire logic                i_prev_place,
    input  wire ttlq_pkg::t_entry    i_next_entry,
    output ttlq_pkg::t_entry         o_entry,
    output logic                     o_place
);

    ttlq_pkg::t_entry r_entry;
    ttlq_pkg::t_entry n_entry;
    logic             w_empty;

    // The cell is empty when its position lies at or beyond the entry count.
    assign w_empty = ttlq_pkg::t_cnt'(i_index) >= i_ctrl.count;

    // The new entry belongs here or further up when this cell is empty or
    // holds a strictly larger TTL; entries of equal TTL stay in front.
    assign o_place = w_empty || (r_entry.ttl > i_ctrl.new_entry.ttl);
    assign o_entry = r_entry;

    // Next entry: keep, take the new entry, take the lower neighbour's entry
    // on insertion, or take the upper neighbour's entry on removal of the head.
    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            ttlq_pkg::OP_INSERT: begin
                if (o_place) begin
                    n_entry = i_prev_place ? i_prev_entry : i_ctrl.new_entry;
                end
            end
            ttlq_pkg::OP_SHIFT: begin
                n_entry = i_next_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Entry storage; contents are meaningful only below the entry count.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

FILE: rtl/ttl_ordered_priority_queue.sv
// Top level of the TTL-ordered priority queue: command decode, cell chain and result register.
// Busy never rises, so a new transaction may be started in every cycle; its result appears
// with o_valid high for exactly one cycle, the cycle after the command is accepted, and must
// be taken then since the receiver cannot stall. The chain of storage cells allows this:
// every cell compares its TTL with the new one and moves its entry one place in the same
// cycle. Entries with equal TTL leave in arrival order. The queue needs no clearing pass
// after reset.
`default_nettype none

`include "assert_macros.svh"

module ttl_ordered_priority_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_ttl,
    input  wire logic [15:0] i_packet_tag,
    input  wire logic [7:0]  i_direction,
    output logic             o_valid,
    output logic             o_ok,
    output logic [7:0]       o_head_ttl,
    output logic [15:0]      o_head_tag,
    output logic [7:0]       o_head_direction,
    output logic [4:0]       o_occupancy
);

    localparam ttlq_pkg::t_cnt FULL_COUNT = ttlq_pkg::t_cnt'(ttlq_pkg::QUEUE_DEPTH);

    ttlq_pkg::t_cnt       r_count;
    ttlq_pkg::t_cnt       n_count;
    logic                 r_valid;
    logic                 r_ok;
    logic                 n_ok;
    ttlq_pkg::t_entry     r_head;
    ttlq_pkg::t_entry     n_head;
    ttlq_pkg::t_cmd       w_cmd;
    ttlq_pkg::t_cell_ctrl w_ctrl;
    logic                 w_accept;
    logic                 w_enq_full;

    ttlq_pkg::t_entry     w_entry [ttlq_pkg::QUEUE_DEPTH];
    logic                 w_place [ttlq_pkg::QUEUE_DEPTH];

    // The block is never busy.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_cmd    = ttlq_pkg::t_cmd'(i_command);

    // Decode the transaction into a cell operation, new count and result.
    always_comb begin
        w_ctrl.op        = ttlq_pkg::OP_HOLD;
        w_ctrl.new_entry = '{ttl: i_ttl, tag: i_packet_tag, dir: i_direction};
        w_ctrl.count     = r_count;
        n_count          = r_count;
        n_ok             = 1'b0;
        n_head           = '0;
        if (w_accept) begin
            case (w_cmd)
                ttlq_pkg::CMD_ENQUEUE: begin
                    if (r_count != FULL_COUNT) begin
                        w_ctrl.op = ttlq_pkg::OP_INSERT;
                        n_count   = r_count + ttlq_pkg::t_cnt'(1);
                        n_ok      = 1'b1;
                    end
                end
                ttlq_pkg::CMD_DEQUEUE: begin
                    if (r_count != '0) begin
                        w_ctrl.op = ttlq_pkg::OP_SHIFT;
                        n_count   = r_count - ttlq_pkg::t_cnt'(1);
                        n_ok      = 1'b1;
                        n_head    = w_entry[0];
                    end
                end
                ttlq_pkg::CMD_PEEK: begin
                    if (r_count != '0) begin
                        n_ok   = 1'b1;
                        n_head = w_entry[0];
                    end
                end
                default: begin
                    n_count = '0;
                    n_ok    = 1'b1;
                end
            endcase
        end
    end

    // Chain of cells; cell zero holds the head of the queue.
    for (genvar g = 0; g < ttlq_pkg::QUEUE_DEPTH; g++) begin : g_cell
        ttlq_pkg::t_entry w_prev_entry;
        logic             w_prev_place;
        ttlq_pkg::t_entry w_next_entry;

        if (g == 0) begin : g_first
            assign w_prev_entry = '0;
            assign w_prev_place = 1'b0;
        end else begin : g_inner
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_place = w_place[g-1];
        end

        if (g == ttlq_pkg::QUEUE_DEPTH - 1) begin : g_last
            assign w_next_entry = '0;
        end else begin : g_body
            assign w_next_entry = w_entry[g+1];
        end

        ttlq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_index      (ttlq_pkg::t_idx'(g)),
            .i_prev_entry (w_prev_entry),
            .i_prev_place (w_prev_place),
            .i_next_entry (w_next_entry),
            .o_entry      (w_entry[g]),
            .o_place      (w_place[g])
        );
    end

    // Control state: entry count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_ok   <= n_ok;
        r_head <= n_head;
    end

    assign o_valid          = r_valid;
    assign o_ok             = r_ok;
    assign o_head_ttl       = r_head.ttl;
    assign o_head_tag       = r_head.tag;
    assign o_head_direction = r_head.dir;
    assign o_occupancy      = ttlq_pkg::t_occ'(r_count);

    // An enqueue that finds the queue full.
    assign w_enq_full = w_accept && (w_cmd == ttlq_pkg::CMD_ENQUEUE) && (r_count == FULL_COUNT);

    // Checks on the queue's own logic.
    `ASSERT_CLK(a_one_result, i_clk, i_rst_n, w_accept |=> o_valid, "command gave no result")
    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= FULL_COUNT, "entry count above depth")
    `ASSERT_CLK(a_full_reject, i_clk, i_rst_n, w_enq_full |=> (!o_ok && $stable(r_count)),
                "enqueue on full queue accepted")
    `ASSERT_CLK(a_head_order, i_clk, i_rst_n,
                (r_count >= ttlq_pkg::t_cnt'(2)) |-> (w_entry[0].ttl <= w_entry[1].ttl),
                "head entries out of TTL order")

endmodule

`default_nettype wire
